@@ rtl/sha_pad_pkg.sv @@
// Shared types and constants for the SHA-256 message padder.
// Used by the front end, command queue, back end and top level; no dependencies.
`timescale 1ns / 1ps

package sha_pad_pkg;

	// Padding constants.
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [7:0] FILL_BYTE = 8'h00;

	// Word positions inside a 16-word block.
	localparam logic [3:0] LEN_HI_IDX = 4'd14;
	localparam logic [3:0] LEN_LO_IDX = 4'd15;

	// Command queue geometry.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = 2;
	localparam int CMD_CNT_W = 3;

	// Command kinds.
	localparam logic CMD_WORD = 1'b0;
	localparam logic CMD_CLOSE = 1'b1;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [3:0]  word_index;
		logic        first_block;
		logic        final_block;
		logic        run_last;
	} out_item_t;

	// One command from the front end to the back end. A word command carries a
	// finished data word; a close command carries the padded word, where it sits,
	// whether an extra block follows and the 64-bit message length in bits.
	typedef struct packed {
		logic        kind;
		logic [31:0] word;
		logic [3:0]  idx;
		logic        first;
		logic        extra;
		logic [63:0] bits;
	} cmd_t;

endpackage

@@ rtl/sha_pad_front.sv @@
// Front end of the SHA-256 message padder: packs bytes, tracks the message
// length and turns each input item into at most one command. Depends on sha_pad_pkg.
`timescale 1ns / 1ps

module sha_pad_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  sha_pad_pkg::in_item_t item,
	output logic                 cmd_push,
	output sha_pad_pkg::cmd_t     cmd
);
	import sha_pad_pkg::*;

	logic [23:0] partial_q;
	logic [5:0]  pos_q;
	logic [60:0] count_q;
	logic        first_q;

	logic        is_byte;
	logic        is_close;
	logic [31:0] padded;

	assign is_byte = item.byte_present;
	assign is_close = !item.byte_present && item.end_of_message;

	// The incomplete word followed by the pad mark and zero fill.
	always_comb begin
		case (pos_q[1:0])
			2'd0: padded = {PAD_MARK, FILL_BYTE, FILL_BYTE, FILL_BYTE};
			2'd1: padded = {partial_q[7:0], PAD_MARK, FILL_BYTE, FILL_BYTE};
			2'd2: padded = {partial_q[15:0], PAD_MARK, FILL_BYTE};
			2'd3: padded = {partial_q[23:0], PAD_MARK};
			default: padded = {PAD_MARK, FILL_BYTE, FILL_BYTE, FILL_BYTE};
		endcase
	end

	always_comb begin
		cmd.kind = is_close ? CMD_CLOSE : CMD_WORD;
		cmd.word = is_close ? padded : {partial_q, item.message_byte};
		cmd.idx = pos_q[5:2];
		cmd.first = first_q;
		cmd.extra = (pos_q[5:3] == 3'b111);
		cmd.bits = {count_q, 3'b000};
		cmd_push = accept && (is_close || (is_byte && (pos_q[1:0] == 2'd3)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			first_q <= 1'b1;
		end else if (accept && is_byte) begin
			if (pos_q[1:0] == 2'd3) begin
				partial_q <= '0;
			end else begin
				partial_q <= {partial_q[15:0], item.message_byte};
			end
			pos_q <= pos_q + 6'd1;
			if (pos_q == 6'd63) begin
				first_q <= 1'b0;
			end
			count_q <= count_q + 61'd1;
		end else if (accept && is_close) begin
			partial_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			first_q <= 1'b1;
		end
	end

endmodule

@@ rtl/sha_pad_fifo.sv @@
// Short command queue between the padder's front and back ends.
// Depends on sha_pad_pkg for the command type and depth.
`timescale 1ns / 1ps

module sha_pad_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sha_pad_pkg::cmd_t wdata,
	input  logic             pop,
	output sha_pad_pkg::cmd_t rdata,
	output logic             full,
	output logic             empty
);
	import sha_pad_pkg::*;

	cmd_t                 slots_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/sha_pad_back.sv @@
// Back end of the SHA-256 message padder: expands commands into block words
// and holds the output register. Depends on sha_pad_pkg.
`timescale 1ns / 1ps

module sha_pad_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha_pad_pkg::cmd_t      cmd,
	input  logic                  cmd_empty,
	output logic                  cmd_pop,
	output sha_pad_pkg::out_item_t result,
	output logic                  empty,
	input  logic                  pop
);
	import sha_pad_pkg::*;

	out_item_t   out_q;
	logic        out_valid_q;
	logic        busy_q;
	logic [3:0]  idx_q;
	logic        second_q;
	logic        extra_q;
	logic        first_q;
	logic [63:0] bits_q;

	logic        taken;
	logic        free;
	logic        start;
	logic        step;
	logic        tail;
	out_item_t   nxt;

	assign taken = pop && out_valid_q;
	assign free = !out_valid_q || taken;
	assign start = !busy_q && !cmd_empty && free;
	assign step = busy_q && free;
	assign cmd_pop = start;
	assign tail = !extra_q || second_q;

	always_comb begin
		if (busy_q) begin
			if (tail && (idx_q == LEN_HI_IDX)) begin
				nxt.msg_word = bits_q[63:32];
			end else if (tail && (idx_q == LEN_LO_IDX)) begin
				nxt.msg_word = bits_q[31:0];
			end else begin
				nxt.msg_word = '0;
			end
			nxt.word_index = idx_q;
			nxt.first_block = first_q && !second_q;
			nxt.final_block = tail;
			nxt.run_last = tail && (idx_q == LEN_LO_IDX);
		end else begin
			nxt.msg_word = cmd.word;
			nxt.word_index = cmd.idx;
			nxt.first_block = cmd.first;
			nxt.final_block = (cmd.kind == CMD_CLOSE) && !cmd.extra;
			nxt.run_last = (cmd.kind == CMD_WORD);
		end
	end

	always_ff @(posedge clk) begin
		if (start || step) begin
			out_q <= nxt;
		end
		if (start) begin
			extra_q <= cmd.extra;
			first_q <= cmd.first;
			bits_q <= cmd.bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
			idx_q <= '0;
			second_q <= 1'b0;
		end else begin
			if (start || step) begin
				out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
			if (start && (cmd.kind == CMD_CLOSE)) begin
				busy_q <= 1'b1;
				idx_q <= cmd.idx + 4'd1;
				second_q <= (cmd.idx == LEN_LO_IDX);
			end else if (step) begin
				if (nxt.run_last) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 4'd1;
				if (idx_q == LEN_LO_IDX) begin
					second_q <= 1'b1;
				end
			end
		end
	end

	assign result = out_q;
	assign empty = !out_valid_q;

endmodule

@@ rtl/sha256_message_padder.sv @@
// Top level of the SHA-256 message padder: front end, command queue, back end.
// Depends on sha_pad_pkg, sha_pad_front, sha_pad_fifo and sha_pad_back.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one item per cycle when push is high and full is
// low. An item carrying a byte appends it to the message; an empty item with
// end_of_message set closes the message; an empty item without it is ignored.
// The result channel behaves as the read side of a queue: while empty is low
// the oldest block word is on result, and pop takes it.
// Every fourth byte produces one word. A closing item produces 3 to 18 words:
// the padded current word, zero fill, an extra block when 56 or more bytes
// already sit in the block, and the 64-bit bit count in words 14 and 15.
// A word passes through the command queue and the output register on its way
// to result, and leaves the back end only when the result side is free. Bytes
// are taken at one per cycle; a closing item occupies the back end while it
// produces its words, and meanwhile the front end keeps taking bytes of the next
// message until the four-entry command queue fills, which raises full.
// When pop stays low the output register holds its word, the back end stops,
// and the queue absorbs commands until full rises. Nothing is lost.
// Reset clears the queue, the output valid flag and the message state; the
// block can accept an item as soon as reset is released.
module sha256_message_padder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sha_pad_pkg::in_item_t  message,
	output logic                  empty,
	input  logic                  pop,
	output sha_pad_pkg::out_item_t result
);
	import sha_pad_pkg::*;

	logic accept;
	logic cmd_push;
	logic cmd_pop;
	logic cmd_full;
	logic cmd_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;

	// The front end can always absorb an item as long as the queue has room.
	assign full = cmd_full;
	assign accept = push && !cmd_full;

	sha_pad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (message),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	sha_pad_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	sha_pad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the SHA-256 message padder (sha256_message_padder).
// Depends on sha_pad_pkg for the item types and padding constants, and on the RTL only.
`timescale 1ns / 1ps

module tb;
	import sha_pad_pkg::*;

	// Scoreboard: a behavioral copy of the padder state and the block words
	// that the accepted message items still owe on the result side.
	class padder_scoreboard;
		out_item_t   owed_words[$];
		logic [23:0] pend_bytes;
		logic [5:0]  blk_pos;
		logic [60:0] msg_bytes;
		logic        first_blk;
		int          failures;
		int          reported;

		function new();
			failures = 0;
			reported = 0;
			clear_message();
		endfunction

		function void clear_message();
			pend_bytes = '0;
			blk_pos = '0;
			msg_bytes = '0;
			first_blk = 1'b1;
		endfunction

		// Places one byte into the block; every fourth byte completes a word.
		function void pack_byte(logic [7:0] b, logic fin);
			out_item_t w;
			if (blk_pos[1:0] == 2'd3) begin
				w.msg_word = {pend_bytes, b};
				w.word_index = blk_pos[5:2];
				w.first_block = first_blk;
				w.final_block = fin;
				w.run_last = 1'b0;
				owed_words.push_back(w);
				pend_bytes = '0;
			end else begin
				pend_bytes = {pend_bytes[15:0], b};
			end
			blk_pos = blk_pos + 6'd1;
			if (blk_pos == 6'd0)
				first_blk = 1'b0;
		endfunction

		// Notes one accepted item and works out the words it produces.
		function void note_item(in_item_t it);
			logic [63:0] bit_len;
			logic        extra;
			int          had;
			int          k;
			out_item_t   tail;
			had = owed_words.size();
			if (it.byte_present) begin
				// A byte always counts as data, even with the end flag set.
				pack_byte(it.message_byte, 1'b0);
				msg_bytes = msg_bytes + 61'd1;
			end else if (it.end_of_message) begin
				bit_len = {msg_bytes, 3'b000};
				extra = (blk_pos >= 6'd56);
				pack_byte(PAD_MARK, !extra);
				if (extra) begin
					while (blk_pos != 6'd0)
						pack_byte(FILL_BYTE, 1'b0);
				end
				while (blk_pos != 6'd56)
					pack_byte(FILL_BYTE, 1'b1);
				for (k = 7; k >= 0; k--)
					pack_byte(bit_len[8*k +: 8], 1'b1);
				clear_message();
			end
			if (owed_words.size() > had) begin
				tail = owed_words.pop_back();
				tail.run_last = 1'b1;
				owed_words.push_back(tail);
			end
		endfunction

		// Compares one popped word against the oldest owed word.
		function void check_word(out_item_t got);
			out_item_t want;
			if (owed_words.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("mismatch at %0t: unexpected word %h", $realtime, got);
				end
				return;
			end
			want = owed_words.pop_front();
			if (got.msg_word !== want.msg_word || got.word_index !== want.word_index ||
					got.first_block !== want.first_block ||
					got.final_block !== want.final_block || got.run_last !== want.run_last) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("mismatch at %0t: word exp %h got %h, idx exp %0d got %0d",
						$realtime, want.msg_word, got.msg_word, want.word_index,
						got.word_index);
					$display("  first exp %b got %b, final exp %b got %b, last exp %b got %b",
						want.first_block, got.first_block, want.final_block,
						got.final_block, want.run_last, got.run_last);
				end
			end
		endfunction

		function int outstanding();
			return owed_words.size();
		endfunction

		// Words still owed at the end of the run are failures too.
		function int total_failures();
			if (owed_words.size() != 0)
				$display("%0d expected words never arrived", owed_words.size());
			return failures + owed_words.size();
		endfunction
	endclass

	localparam int ITEM_GOAL = 310;
	localparam int QUIET_FROM = 270;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  message = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	// Set for the closing stretch of the run: no idling on either side.
	logic quiet = 1'b0;
	int   stall_left = 0;
	int   items_sent = 0;

	padder_scoreboard sb = new();

	sha256_message_padder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.message(message),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	// Offers one item and holds it until the padder takes it. Items that the
	// padder ignores (empty and no end flag) do not count toward the goal.
	task automatic send_item(input logic [7:0] b, input logic present, input logic last);
		in_item_t it;
		it.message_byte = b;
		it.byte_present = present;
		it.end_of_message = last;
		push <= 1'b1;
		message <= it;
		do
			@(posedge clk);
		while (full);
		sb.note_item(it);
		if (present || last)
			items_sent++;
	endtask

	// Drops push for a while; the payload carries junk during the gap.
	task automatic idle_sender(input int cycles);
		push <= 1'b0;
		message <= in_item_t'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Random sender gaps of random length, none in the quiet stretch.
	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 5) == 0)
			idle_sender($urandom_range(1, 13));
	endtask

	// Sends one message of the given length with random bytes, then closes it.
	// A little noise rides along: ignored empty items, and bytes that carry the
	// end flag, which the padder must treat as plain data.
	task automatic send_message(input int len);
		int n;
		for (n = 0; n < len; n++) begin
			maybe_idle();
			if ($urandom_range(0, 11) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, $urandom_range(0, 9) == 0);
		end
		maybe_idle();
		send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Result side: checks every popped word and stalls pop in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left <= 0;
		end else begin
			if (pop && !empty)
				sb.check_word(result);
			if (quiet) begin
				pop <= 1'b1;
			end else if (stall_left != 0) begin
				pop <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				stall_left <= $urandom_range(0, 12);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Main stimulus sequence.
	initial begin
		int msg_count;
		int drain_wait;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. An ignored empty item, then a close of an empty
		// message (zero bit count), then a message whose first byte carries
		// the end flag and whose bytes hit both extremes, closed by an empty
		// item with a nonzero byte field, then a one-byte message.
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'hC3, 1'b0, 1'b1);
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);

		// Random part. The first messages are sized so that the close lands
		// just below the length field, right at its start (the longest close,
		// with an extra block) and on the last byte of a block.
		msg_count = 0;
		while (items_sent < ITEM_GOAL) begin
			if (items_sent >= QUIET_FROM)
				quiet <= 1'b1;
			case (msg_count)
				0: begin
					send_message(55);
				end
				1: begin
					send_message(56);
				end
				2: begin
					send_message(63);
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						send_message($urandom_range(0, 70));
					else
						send_message($urandom_range(0, 12));
				end
			endcase
			msg_count++;
			// Now and then hold off until every owed word has been popped.
			if (!quiet && (msg_count == 4 || $urandom_range(0, 7) == 0)) begin
				push <= 1'b0;
				while (sb.outstanding() != 0)
					@(posedge clk);
			end
		end
		quiet <= 1'b1;
		push <= 1'b0;

		// Drain, then keep running so that stray words can show before the check.
		drain_wait = 0;
		while (sb.outstanding() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (30) @(posedge clk);

		if (sb.total_failures() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
